/* design/ilst_pkg.sv */
// Shared constants, types and word helpers for the indexed list block.
`timescale 1ns / 1ps
`default_nettype none

package ilst_pkg;

  localparam int CAPACITY  = 32;
  localparam int WORD_BITS = 32;
  localparam int POS_BITS  = 6;
  localparam int OUT_BITS  = 32;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int ADDR_BITS = $clog2(CAPACITY);
  localparam int CMP_BITS  = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

  localparam logic [CMP_BITS-1:0] CAPACITY_CMP = CMP_BITS'(CAPACITY);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_ERASE  = 1'b1
  } op_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } ram_wr_t;

  // Incoming 32-bit value to a stored word: low bits kept, zero fill above 32.
  function automatic word_t to_word(logic [OUT_BITS-1:0] v);
    logic [63:0] x;
    x = {32'b0, v};
    return x[WORD_BITS-1:0];
  endfunction

  // Stored word to 32 output bits, sign-extended from WORD_BITS.
  function automatic logic [OUT_BITS-1:0] from_word(word_t w);
    logic [63:0] x;
    x = 64'($signed(w));
    return x[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/indexed_list_insert_erase.sv */
// Top level: sequencer that inserts or erases list entries one move at a time.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   request  | in_valid / in_ready   | operation, position, value
//   result   | out_valid / out_ready | success, list_length, entry_at_position
//
// One request at a time; in_ready is high only when no request is in progress.
// An accepted request moves entries one at a time and then, for an insert, writes
// the new value; a rejected request goes straight to reading out the result. Each move is
// a read, then a write, through the store's separate read and write ports.
// A result is held until out_ready; the next request is taken after that.
// rst clears the length and the sequencer; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_erase (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 operation,
  input  wire logic [5:0]           position,
  input  wire logic signed [31:0]   value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      success,
  output logic [5:0]                list_length,
  output logic signed [31:0]        entry_at_position
);
  import ilst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_RD,
    S_WR,
    S_PUT,
    S_FETCH,
    S_LOAD,
    S_DONE
  } state_t;

  state_t              state;
  op_t                 op;
  logic [CMP_BITS-1:0] pos;
  logic [CMP_BITS-1:0] idx;
  logic [CNT_BITS-1:0] count;
  word_t               val;

  logic [CMP_BITS-1:0] cnt_x;
  logic [CMP_BITS-1:0] pos_in;
  logic [CMP_BITS-1:0] idx_m1;
  logic                ins_ok;
  logic                era_ok;
  logic                more;
  ram_wr_t             wr;
  addr_t               rd_addr;
  word_t               rd_data;

  assign cnt_x  = CMP_BITS'(count);
  assign pos_in = CMP_BITS'(position);
  assign idx_m1 = idx - CMP_BITS'(1);
  assign ins_ok = (cnt_x < CAPACITY_CMP) && (pos_in <= cnt_x);
  assign era_ok = pos_in < cnt_x;
  assign more   = (op == OP_INSERT) ? (idx > pos) : (idx < cnt_x);
  assign in_ready = (state == S_IDLE);
  assign list_length = 6'(count);

  always_comb begin
    wr      = '0;
    rd_addr = pos[ADDR_BITS-1:0];
    unique case (state)
      S_RD: begin
        rd_addr = (op == OP_INSERT) ? idx_m1[ADDR_BITS-1:0] : idx[ADDR_BITS-1:0];
      end
      S_WR: begin
        wr.en   = 1'b1;
        wr.addr = (op == OP_INSERT) ? idx[ADDR_BITS-1:0] : idx_m1[ADDR_BITS-1:0];
        wr.data = rd_data;
      end
      S_PUT: begin
        wr.en   = 1'b1;
        wr.addr = pos[ADDR_BITS-1:0];
        wr.data = val;
      end
      default: begin
      end
    endcase
  end

  ilst_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op  <= op_t'(operation);
            pos <= pos_in;
            val <= to_word(value);
            if (op_t'(operation) == OP_INSERT) begin
              idx     <= cnt_x;
              success <= ins_ok;
              state   <= ins_ok ? S_STEP : S_FETCH;
            end else begin
              idx     <= pos_in + CMP_BITS'(1);
              success <= era_ok;
              state   <= era_ok ? S_STEP : S_FETCH;
            end
          end
        end
        S_STEP: begin
          if (more) begin
            state <= S_RD;
          end else if (op == OP_INSERT) begin
            state <= S_PUT;
          end else begin
            count <= count - CNT_BITS'(1);
            state <= S_FETCH;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          idx   <= (op == OP_INSERT) ? idx_m1 : idx + CMP_BITS'(1);
          state <= S_STEP;
        end
        S_PUT: begin
          count <= count + CNT_BITS'(1);
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          entry_at_position <= (pos < cnt_x) ? $signed(from_word(rd_data)) : '0;
          out_valid         <= 1'b1;
          state             <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/ilst_ram.sv */
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ilst_ram (
  input  wire logic            clk,
  input  wire ilst_pkg::ram_wr_t wr,
  input  wire ilst_pkg::addr_t rd_addr,
  output ilst_pkg::word_t      rd_data
);
  import ilst_pkg::*;

  word_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* verif/tb_indexed_list_insert_erase.sv */
// Testbench for indexed_list_insert_erase: directed table plus random insert/erase with checking.
`timescale 1ns / 1ps

module tb_indexed_list_insert_erase;
  import ilst_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 780;
  localparam int PHASE_ITEMS  = 195;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic        success;
    logic [5:0]  length;
    logic [31:0] entry;
  } list_result_t;

  typedef struct packed {
    op_t          op;
    logic [5:0]   pos;
    logic [31:0]  val;
    logic         typed;
    list_result_t res;
  } list_cmd_t;

  localparam int NUM_DIRECTED = 24;

  localparam list_cmd_t DIRECTED_CMDS [NUM_DIRECTED] = '{
    '{OP_ERASE,  6'd0,  32'h0000_0000, 1'b1, '{1'b0, 6'd0, 32'h0000_0000}},
    '{OP_INSERT, 6'd1,  32'h1234_5678, 1'b1, '{1'b0, 6'd0, 32'h0000_0000}},
    '{OP_INSERT, 6'd63, 32'hFFFF_FFFF, 1'b1, '{1'b0, 6'd0, 32'h0000_0000}},
    '{OP_ERASE,  6'd63, 32'h0000_0000, 1'b1, '{1'b0, 6'd0, 32'h0000_0000}},
    '{OP_INSERT, 6'd0,  32'h7FFF_FFFF, 1'b1, '{1'b1, 6'd1, 32'h7FFF_FFFF}},
    '{OP_INSERT, 6'd0,  32'h8000_0000, 1'b1, '{1'b1, 6'd2, 32'h8000_0000}},
    '{OP_INSERT, 6'd2,  32'hFFFF_FFFF, 1'b1, '{1'b1, 6'd3, 32'hFFFF_FFFF}},
    '{OP_INSERT, 6'd4,  32'h0000_0005, 1'b1, '{1'b0, 6'd3, 32'h0000_0000}},
    '{OP_ERASE,  6'd3,  32'hDEAD_BEEF, 1'b1, '{1'b0, 6'd3, 32'h0000_0000}},
    '{OP_INSERT, 6'd1,  32'h0000_0000, 1'b0, '0},
    '{OP_INSERT, 6'd3,  32'h5555_5555, 1'b0, '0},
    '{OP_INSERT, 6'd4,  32'hAAAA_AAAA, 1'b0, '0},
    '{OP_ERASE,  6'd63, 32'h0000_0000, 1'b1, '{1'b0, 6'd6, 32'h0000_0000}},
    '{OP_ERASE,  6'd0,  32'hFFFF_FFFF, 1'b0, '0},
    '{OP_ERASE,  6'd4,  32'h0000_0000, 1'b0, '0},
    '{OP_ERASE,  6'd1,  32'h0000_0000, 1'b0, '0},
    '{OP_INSERT, 6'd3,  32'h0F0F_F0F0, 1'b0, '0},
    '{OP_INSERT, 6'd33, 32'h0000_0001, 1'b1, '{1'b0, 6'd4, 32'h0000_0000}},
    '{OP_ERASE,  6'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_ERASE,  6'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_ERASE,  6'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_ERASE,  6'd0,  32'h0000_0000, 1'b0, '0},
    '{OP_ERASE,  6'd0,  32'h0000_0000, 1'b1, '{1'b0, 6'd0, 32'h0000_0000}},
    '{OP_INSERT, 6'd0,  32'h0000_0001, 1'b1, '{1'b1, 6'd1, 32'h0000_0001}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = 1'b0;
  logic [5:0]         position = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               success;
  logic [5:0]         list_length;
  logic signed [31:0] entry_at_position;

  word_t        list_words[$];
  list_result_t expected_results[$];
  bit           growing = 1'b1;
  int           sender_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           fail_count = 0;
  int           cycle_count = 0;

  indexed_list_insert_erase DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .success(success),
    .list_length(list_length),
    .entry_at_position(entry_at_position)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic list_result_t apply_list_op(op_t op, logic [5:0] pos, logic [31:0] val);
    list_result_t r;
    r.success = 1'b0;
    if (op == OP_INSERT) begin
      if (list_words.size() < CAPACITY && pos <= list_words.size()) begin
        list_words.insert(pos, word_t'(val));
        r.success = 1'b1;
      end
    end else if (pos < list_words.size()) begin
      list_words.delete(pos);
      r.success = 1'b1;
    end
    r.length = 6'(list_words.size());
    r.entry  = (pos < list_words.size()) ? 32'($signed(list_words[pos])) : 32'h0;
    return r;
  endfunction

  // Mostly legal moves that drift the length between empty and full, with some noise.
  task automatic pick_random_request(output op_t op, output logic [5:0] pos,
                                     output logic [31:0] val);
    int n;
    int r;
    n = list_words.size();
    if (n == CAPACITY && $urandom_range(3) == 0) begin
      growing = 1'b0;
    end else if (n == 0 && $urandom_range(3) == 0) begin
      growing = 1'b1;
    end else if ($urandom_range(63) == 0) begin
      growing = !growing;
    end
    r = $urandom_range(99);
    if (r < 10) begin
      op  = op_t'($urandom_range(1));
      pos = 6'($urandom_range(63));
    end else begin
      op = ((r < 85) == growing) ? OP_INSERT : OP_ERASE;
      if (op == OP_INSERT) begin
        case ($urandom_range(3))
          0: pos = 6'd0;
          1: pos = 6'(n);
          default: pos = 6'($urandom_range(n));
        endcase
      end else if (n == 0) begin
        pos = 6'd0;
      end else begin
        case ($urandom_range(3))
          0: pos = 6'd0;
          1: pos = 6'(n - 1);
          default: pos = 6'($urandom_range(n - 1));
        endcase
      end
    end
    case ($urandom_range(7))
      0: val = 32'h8000_0000;
      1: val = 32'h7FFF_FFFF;
      2: val = 32'h0000_0000;
      3: val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
  endtask

  task automatic send_request(op_t op, logic [5:0] pos, logic [31:0] val, logic typed,
                              list_result_t typed_res);
    list_result_t predicted;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_op(op, pos, val);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  initial begin
    op_t         op;
    logic [5:0]  pos;
    logic [31:0] val;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_CMDS[i]) begin
      send_request(DIRECTED_CMDS[i].op, DIRECTED_CMDS[i].pos, DIRECTED_CMDS[i].val,
                   DIRECTED_CMDS[i].typed, DIRECTED_CMDS[i].res);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i / PHASE_ITEMS)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 86;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 86;
        end
        default: begin
          sender_idle_pct = 13;
          recv_stall_pct  = 13;
        end
      endcase
      pick_random_request(op, pos, val);
      send_request(op, pos, val, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    list_result_t exp;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result success=%0b length=%0d entry=%h", $time,
                 success, list_length, entry_at_position);
        fail_count++;
      end else begin
        exp = expected_results.pop_front();
        if (success !== exp.success) begin
          $display("%0t: success expected %0b got %0b", $time, exp.success, success);
          fail_count++;
        end
        if (list_length !== exp.length) begin
          $display("%0t: list_length expected %0d got %0d", $time, exp.length, list_length);
          fail_count++;
        end
        if (entry_at_position !== exp.entry) begin
          $display("%0t: entry_at_position expected %h got %h", $time, exp.entry,
                   entry_at_position);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

/* indexed_list_insert_erase.f */
design/ilst_pkg.sv
design/ilst_ram.sv
design/indexed_list_insert_erase.sv
verif/tb_indexed_list_insert_erase.sv
